// ----- src/itpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// itpsc_pkg
// shared types, codes and constants of the idle timeout power state controller
// ----------------------------------------------------------------------------
package itpsc_pkg;

    localparam int KindWidth     = 2;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 24;
    localparam int ActWidth      = 26;
    localparam int AsleepWidth   = 24;
    localparam int StatsWidth    = 14;
    localparam int AvgWidth      = 17;
    localparam int DrawWidth     = 9;

    typedef enum logic [1:0] {
        MODE_ACTIVE = 2'd0,
        MODE_IDLE   = 2'd1,
        MODE_SLEEP  = 2'd2
    } mode_t;

    typedef enum logic [KindWidth-1:0] {
        KIND_TICK     = 2'd0,
        KIND_ACTIVITY = 2'd1,
        KIND_STAY     = 2'd2,
        KIND_PIN      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_PIN   = 2'd1,
        CAUSE_TIMER = 2'd2
    } cause_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_IDLE_TIMEOUT = 2'd0,
        CFG_SLEEP_GRACE  = 2'd1,
        CFG_TIMER_WAKE   = 2'd2,
        CFG_STATS_PERIOD = 2'd3
    } cfg_index_t;

    localparam logic [23:0] IdleTimeoutReset = 24'd30000;
    localparam logic [15:0] SleepGraceReset  = 16'd1000;
    localparam logic [23:0] TimerWakeReset   = 24'd60000;
    localparam logic [13:0] StatsPeriodReset = 14'd10000;

    localparam logic [DrawWidth-1:0] DrawActive = 9'd450;
    localparam logic [DrawWidth-1:0] DrawIdle   = 9'd250;
    localparam logic [DrawWidth-1:0] DrawSleep  = 9'd85;

    // ceil(2^24 / 10), exact quotient for dividends below 2^22
    localparam logic [20:0] RecipTen = 21'd1677722;

    typedef struct packed {
        logic [23:0] idle_timeout;
        logic [15:0] sleep_grace;
        logic [23:0] timer_wake;
        logic [13:0] stats_period;
    } cfg_t;

    typedef struct packed {
        mode_t                  mode;
        logic                   keep_awake;
        logic [ActWidth-1:0]    since_act;
        logic [AsleepWidth-1:0] asleep;
        logic [StatsWidth-1:0]  since_stats;
        logic [31:0]            sleep_accum;
        logic [31:0]            wake_tally;
        cause_t                 cause;
        logic [AvgWidth-1:0]    avg;
    } state_t;

    function automatic logic [DrawWidth-1:0] draw_of(mode_t m);
        logic [DrawWidth-1:0] d;
        unique case (m)
            MODE_ACTIVE: d = DrawActive;
            MODE_IDLE:   d = DrawIdle;
            default:     d = DrawSleep;
        endcase
        return d;
    endfunction

endpackage

// ----- src/itpsc_step.sv -----
// ----------------------------------------------------------------------------
// itpsc_step
// next-state logic for one transaction: mode rules, wake statistics, average
// ----------------------------------------------------------------------------
module itpsc_step
(
    input  itpsc_pkg::state_t cur,
    input  itpsc_pkg::cfg_t   cfg,
    input  itpsc_pkg::kind_t  kind,
    input  logic              awake_hold,
    output itpsc_pkg::state_t nxt,
    output logic              woke
);
    import itpsc_pkg::*;

    logic [ActWidth-1:0]    act_inc;
    logic [StatsWidth-1:0]  stats_inc;
    logic [AsleepWidth-1:0] asleep_inc;
    logic [24:0]            sleep_thr;
    logic                   idle_due;
    logic [20:0]            avg_sum;
    logic [41:0]            avg_prod;
    logic [AvgWidth-1:0]    avg_new;

    assign act_inc    = (&cur.since_act) ? cur.since_act : cur.since_act + 1'b1;
    assign stats_inc  = (&cur.since_stats) ? cur.since_stats : cur.since_stats + 1'b1;
    assign asleep_inc = (&cur.asleep) ? cur.asleep : cur.asleep + 1'b1;
    assign sleep_thr  = {1'b0, cfg.idle_timeout} + {9'd0, cfg.sleep_grace};
    assign idle_due   = !cur.keep_awake && (act_inc >= {2'b00, cfg.idle_timeout});

    // (9 * avg + draw * 256) / 10 via reciprocal multiply
    assign avg_sum  = {1'b0, cur.avg, 3'b000} + {4'd0, cur.avg}
                    + {4'd0, draw_of(cur.mode), 8'd0};
    assign avg_prod = avg_sum * RecipTen;
    assign avg_new  = avg_prod[40:24];

    always_comb
    begin
        nxt  = cur;
        woke = 1'b0;
        unique case (kind)
            KIND_TICK:
            begin
                nxt.since_act   = act_inc;
                nxt.since_stats = stats_inc;
                if (cur.mode == MODE_SLEEP)
                begin
                    nxt.asleep = asleep_inc;
                    if (asleep_inc >= cfg.timer_wake)
                    begin
                        nxt.sleep_accum = cur.sleep_accum + {8'd0, asleep_inc};
                        nxt.wake_tally  = cur.wake_tally + 32'd1;
                        nxt.cause       = CAUSE_TIMER;
                        nxt.mode        = MODE_ACTIVE;
                        nxt.since_act   = '0;
                        woke            = 1'b1;
                    end
                end
                else
                begin
                    if (cur.since_stats >= cfg.stats_period)
                    begin
                        nxt.avg         = avg_new;
                        nxt.since_stats = '0;
                    end
                    if (cur.mode == MODE_ACTIVE)
                    begin
                        if (idle_due)
                        begin
                            nxt.mode = MODE_IDLE;
                        end
                    end
                    else if (act_inc > {1'b0, sleep_thr})
                    begin
                        nxt.mode   = MODE_SLEEP;
                        nxt.asleep = '0;
                    end
                    else if (!idle_due)
                    begin
                        nxt.mode      = MODE_ACTIVE;
                        nxt.since_act = '0;
                    end
                end
            end
            KIND_ACTIVITY:
            begin
                nxt.since_act = '0;
                nxt.mode      = MODE_ACTIVE;
            end
            KIND_STAY:
            begin
                nxt.keep_awake = awake_hold;
                if (awake_hold && cur.mode != MODE_ACTIVE)
                begin
                    nxt.mode      = MODE_ACTIVE;
                    nxt.since_act = '0;
                end
            end
            default:
            begin
                if (cur.mode == MODE_SLEEP)
                begin
                    nxt.sleep_accum = cur.sleep_accum + {8'd0, cur.asleep};
                    nxt.wake_tally  = cur.wake_tally + 32'd1;
                    nxt.cause       = CAUSE_PIN;
                    nxt.mode        = MODE_ACTIVE;
                    nxt.since_act   = '0;
                    woke            = 1'b1;
                end
            end
        endcase
    end

endmodule

// ----- src/idle_timeout_power_state_controller.sv -----
// ----------------------------------------------------------------------------
// idle_timeout_power_state_controller
// power mode controller with idle timeout, light sleep, wake statistics and
// running average current estimate
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   kind, awake_hold
// out      output     out_valid/out_stall mode, low_power, consumption_tenth_ma,
//                                         average_consumption, woke, wake_total,
//                                         slept_ms_total, wake_reason
// cfg      input      cfg_write           cfg_index, cfg_data
//
// one transaction per cycle sustained while out_stall is low; an accepted input
// passes the input register, then the state and result registers, to result valid
// the state update is a single pass of logic from the input register
// reset restores the register defaults and clears all state
// a stalled result holds the state; the input register fills and then stalls
// ----------------------------------------------------------------------------
module idle_timeout_power_state_controller
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [itpsc_pkg::KindWidth-1:0]         kind,
    input  logic                                    awake_hold,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [1:0]                              mode,
    output logic                                    low_power,
    output logic [itpsc_pkg::DrawWidth-1:0]         consumption_tenth_ma,
    output logic [itpsc_pkg::AvgWidth-1:0]          average_consumption,
    output logic                                    woke,
    output logic [31:0]                             wake_total,
    output logic [31:0]                             slept_ms_total,
    output logic [1:0]                              wake_reason,
    input  logic                                    cfg_write,
    input  logic [itpsc_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [itpsc_pkg::CfgDataWidth-1:0]      cfg_data
);
    import itpsc_pkg::*;

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    kind_t  kind_reg;
    logic   stay_reg;
    logic   in_vld_reg;
    logic   out_vld_reg;
    logic   woke_reg;
    logic   woke_next;
    logic   advance;
    logic   in_take;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_timeout <= IdleTimeoutReset;
            cfg_reg.sleep_grace  <= SleepGraceReset;
            cfg_reg.timer_wake   <= TimerWakeReset;
            cfg_reg.stats_period <= StatsPeriodReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IDLE_TIMEOUT: cfg_reg.idle_timeout <= cfg_data;
                CFG_SLEEP_GRACE:  cfg_reg.sleep_grace  <= cfg_data[15:0];
                CFG_TIMER_WAKE:   cfg_reg.timer_wake   <= cfg_data;
                default:          cfg_reg.stats_period <= cfg_data[13:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= kind_t'(kind);
            stay_reg <= awake_hold;
        end
    end

    itpsc_step u_step
    (
        .cur        (state_reg),
        .cfg        (cfg_reg),
        .kind       (kind_reg),
        .awake_hold (stay_reg),
        .nxt        (state_next),
        .woke       (woke_next)
    );

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= MODE_ACTIVE;
            state_reg.keep_awake  <= 1'b0;
            state_reg.since_act   <= '0;
            state_reg.asleep      <= '0;
            state_reg.since_stats <= '0;
            state_reg.sleep_accum <= '0;
            state_reg.wake_tally  <= '0;
            state_reg.cause       <= CAUSE_NONE;
            state_reg.avg         <= '0;
            woke_reg              <= 1'b0;
            out_vld_reg           <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
                woke_reg  <= woke_next;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // result outputs
    always_comb
    begin
        mode                 = state_reg.mode;
        low_power            = (state_reg.mode != MODE_ACTIVE);
        consumption_tenth_ma = draw_of(state_reg.mode);
        average_consumption  = state_reg.avg;
        woke                 = woke_reg;
        wake_total           = state_reg.wake_tally;
        slept_ms_total       = state_reg.sleep_accum;
        wake_reason          = state_reg.cause;
        out_valid            = out_vld_reg;
    end

endmodule

// ----- verif/power_state_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// power_state_checker
// Watches the input, output and register ports of the idle timeout power
// state controller. Each input transaction is run through a local copy of
// the controller state and the expected report is queued. Each output
// transaction is compared field by field with the oldest queued report.
// ----------------------------------------------------------------------------
module power_state_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [itpsc_pkg::KindWidth-1:0]      kind,
    input  logic                                 awake_hold,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [1:0]                           mode,
    input  logic                                 low_power,
    input  logic [itpsc_pkg::DrawWidth-1:0]      consumption_tenth_ma,
    input  logic [itpsc_pkg::AvgWidth-1:0]       average_consumption,
    input  logic                                 woke,
    input  logic [31:0]                          wake_total,
    input  logic [31:0]                          slept_ms_total,
    input  logic [1:0]                           wake_reason,
    input  logic                                 cfg_write,
    input  logic [itpsc_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [itpsc_pkg::CfgDataWidth-1:0]   cfg_data,
    output int                                   mismatches,
    output int                                   pending
);
    import itpsc_pkg::*;

    typedef struct {
        mode_t                 mode;
        logic                  low_power;
        logic [DrawWidth-1:0]  draw;
        logic [AvgWidth-1:0]   avg;
        logic                  woke;
        logic [31:0]           wakes;
        logic [31:0]           slept;
        cause_t                reason;
    } power_report_t;

    power_report_t queued_reports[$];
    power_report_t want;
    power_report_t fresh;
    int            errors;

    logic [23:0]   idle_limit;
    logic [15:0]   grace_ms;
    logic [23:0]   timer_limit;
    logic [13:0]   stats_period;

    mode_t                   cur_mode;
    logic                    keep_on;
    logic [ActWidth-1:0]     idle_ms;
    logic [AsleepWidth-1:0]  sleep_ms;
    logic [StatsWidth-1:0]   stats_ms;
    logic [31:0]             slept_sum;
    logic [31:0]             wakes;
    cause_t                  wake_cause;
    logic [AvgWidth-1:0]     avg_q8;

    function automatic logic [DrawWidth-1:0] draw_for(mode_t m);
        return (m == MODE_ACTIVE) ? DrawActive : ((m == MODE_IDLE) ? DrawIdle : DrawSleep);
    endfunction

    function automatic logic idle_condition();
        return !keep_on && (idle_ms >= idle_limit);
    endfunction

    task automatic end_sleep(cause_t c);
        slept_sum  = slept_sum + 32'(sleep_ms);
        wakes      = wakes + 32'd1;
        wake_cause = c;
        cur_mode   = MODE_ACTIVE;
        idle_ms    = '0;
    endtask

    task automatic advance_power_state(kind_t k, logic bit_in, output power_report_t r);
        logic [StatsWidth-1:0] prev_stats;
        int unsigned           sum;
        logic                  woke_now;
        woke_now   = 1'b0;
        prev_stats = stats_ms;
        case (k)
            KIND_TICK:
            begin
                if (idle_ms != '1)
                    idle_ms = idle_ms + 1'b1;
                if (stats_ms != '1)
                    stats_ms = stats_ms + 1'b1;
                if (cur_mode == MODE_SLEEP)
                begin
                    if (sleep_ms != '1)
                        sleep_ms = sleep_ms + 1'b1;
                    if (sleep_ms >= timer_limit)
                    begin
                        end_sleep(CAUSE_TIMER);
                        woke_now = 1'b1;
                    end
                end
                else
                begin
                    // average uses the mode held before this tick
                    if (prev_stats >= stats_period)
                    begin
                        sum      = 9 * int'(avg_q8) + 256 * int'(draw_for(cur_mode));
                        avg_q8   = AvgWidth'(sum / 10);
                        stats_ms = '0;
                    end
                    if (cur_mode == MODE_ACTIVE)
                    begin
                        if (idle_condition())
                            cur_mode = MODE_IDLE;
                    end
                    else if (32'(idle_ms) > 32'(idle_limit) + 32'(grace_ms))
                    begin
                        cur_mode = MODE_SLEEP;
                        sleep_ms = '0;
                    end
                    else if (!idle_condition())
                    begin
                        cur_mode = MODE_ACTIVE;
                        idle_ms  = '0;
                    end
                end
            end
            KIND_ACTIVITY:
            begin
                idle_ms  = '0;
                cur_mode = MODE_ACTIVE;
            end
            KIND_STAY:
            begin
                keep_on = bit_in;
                if (bit_in && cur_mode != MODE_ACTIVE)
                begin
                    cur_mode = MODE_ACTIVE;
                    idle_ms  = '0;
                end
            end
            default:
            begin
                if (cur_mode == MODE_SLEEP)
                begin
                    end_sleep(CAUSE_PIN);
                    woke_now = 1'b1;
                end
            end
        endcase
        r.mode      = cur_mode;
        r.low_power = (cur_mode != MODE_ACTIVE);
        r.draw      = draw_for(cur_mode);
        r.avg       = avg_q8;
        r.woke      = woke_now;
        r.wakes     = wakes;
        r.slept     = slept_sum;
        r.reason    = wake_cause;
    endtask

    task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                     actual);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit   = IdleTimeoutReset;
            grace_ms     = SleepGraceReset;
            timer_limit  = TimerWakeReset;
            stats_period = StatsPeriodReset;
            cur_mode     = MODE_ACTIVE;
            keep_on      = 1'b0;
            idle_ms      = '0;
            sleep_ms     = '0;
            stats_ms     = '0;
            slept_sum    = '0;
            wakes        = '0;
            wake_cause   = CAUSE_NONE;
            avg_q8       = '0;
            errors       = 0;
            queued_reports.delete();
            mismatches   <= 0;
            pending      <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (queued_reports.size() == 0)
                begin
                    $display("%0t: result transaction with no expected result, actual mode %0d",
                             $time, mode);
                    errors++;
                end
                else
                begin
                    want = queued_reports.pop_front();
                    check_field("mode", 32'(want.mode), 32'(mode));
                    check_field("low_power", 32'(want.low_power), 32'(low_power));
                    check_field("consumption_tenth_ma", 32'(want.draw),
                                32'(consumption_tenth_ma));
                    check_field("average_consumption", 32'(want.avg),
                                32'(average_consumption));
                    check_field("woke", 32'(want.woke), 32'(woke));
                    check_field("wake_total", want.wakes, wake_total);
                    check_field("slept_ms_total", want.slept, slept_ms_total);
                    check_field("wake_reason", 32'(want.reason), 32'(wake_reason));
                end
            end
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_IDLE_TIMEOUT: idle_limit   = cfg_data[23:0];
                    CFG_SLEEP_GRACE:  grace_ms     = cfg_data[15:0];
                    CFG_TIMER_WAKE:   timer_limit  = cfg_data[23:0];
                    default:          stats_period = cfg_data[13:0];
                endcase
            end
            if (in_valid && !in_stall)
            begin
                advance_power_state(kind_t'(kind), awake_hold, fresh);
                queued_reports.push_back(fresh);
            end
            pending    <= queued_reports.size();
            mismatches <= errors;
        end
    end

endmodule

// ----- verif/idle_timeout_power_state_controller_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// idle_timeout_power_state_controller_test
// Drives the power state controller with directed sequences through idle,
// light sleep, timer and pin wakes, then with random tick-heavy traffic under
// several register settings, with random input gaps and output stalls.
// The checker beside the block predicts and compares every report.
// ----------------------------------------------------------------------------
module idle_timeout_power_state_controller_test;
    import itpsc_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int PhaseItems  = 128;
    localparam int RandPhases  = 8;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [KindWidth-1:0]      kind = '0;
    logic                      awake_hold = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [1:0]                mode;
    logic                      low_power;
    logic [DrawWidth-1:0]      consumption_tenth_ma;
    logic [AvgWidth-1:0]       average_consumption;
    logic                      woke;
    logic [31:0]               wake_total;
    logic [31:0]               slept_ms_total;
    logic [1:0]                wake_reason;
    logic                      cfg_write = 1'b0;
    logic [CfgIndexWidth-1:0]  cfg_index = '0;
    logic [CfgDataWidth-1:0]   cfg_data = '0;

    int mismatches;
    int pending;
    int sent_count = 0;
    int cycle_count = 0;
    bit long_hold_done = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    idle_timeout_power_state_controller dut
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .kind                 (kind),
        .awake_hold           (awake_hold),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .mode                 (mode),
        .low_power            (low_power),
        .consumption_tenth_ma (consumption_tenth_ma),
        .average_consumption  (average_consumption),
        .woke                 (woke),
        .wake_total           (wake_total),
        .slept_ms_total       (slept_ms_total),
        .wake_reason          (wake_reason),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    power_state_checker checker_i
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .kind                 (kind),
        .awake_hold           (awake_hold),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .mode                 (mode),
        .low_power            (low_power),
        .consumption_tenth_ma (consumption_tenth_ma),
        .average_consumption  (average_consumption),
        .woke                 (woke),
        .wake_total           (wake_total),
        .slept_ms_total       (slept_ms_total),
        .wake_reason          (wake_reason),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .mismatches           (mismatches),
        .pending              (pending)
    );

    task automatic send_item(kind_t k, logic bit_in);
        in_valid   <= 1'b1;
        kind       <= k;
        awake_hold <= bit_in;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
    endtask

    task automatic wait_all_reports();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [CfgDataWidth-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_timing(logic [23:0] idle, logic [15:0] grace, logic [23:0] timer,
                              logic [13:0] period);
        write_register(CFG_IDLE_TIMEOUT, idle);
        write_register(CFG_SLEEP_GRACE, {8'($urandom), grace});
        write_register(CFG_TIMER_WAKE, timer);
        write_register(CFG_STATS_PERIOD, {10'($urandom), period});
        cfg_write <= 1'b0;
    endtask

    task automatic send_random_phase(int count);
        int    sent;
        int    burst;
        int    gap;
        int    tick_pct;
        kind_t k;
        sent     = 0;
        tick_pct = $urandom_range(55, 85);
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                if ($urandom_range(0, 99) < tick_pct)
                    k = KIND_TICK;
                else
                    k = kind_t'($urandom_range(1, 3));
                send_item(k, $urandom_range(0, 99) < 35);
                sent++;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // receiver stalls
    initial
    begin
        int seg;
        int len;
        int pct;
        forever
        begin
            if (!long_hold_done && sent_count > 300 && in_valid)
            begin
                out_stall <= 1'b1;
                repeat (64) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                seg = $urandom_range(0, 2);
                len = $urandom_range(8, 48);
                pct = (seg == 0) ? 0 : ((seg == 1) ? 30 : 75);
                repeat (len)
                begin
                    out_stall <= ($urandom_range(0, 99) < pct);
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: pin ignored outside sleep, each kind at least once
        send_item(KIND_PIN, 1'b1);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_ACTIVITY, 1'b0);
        send_item(KIND_STAY, 1'b1);
        send_item(KIND_STAY, 1'b0);
        send_item(KIND_TICK, 1'b0);
        wait_all_reports();

        // short timeouts, average on every tick outside sleep
        set_timing(24'd1, 16'd1, 24'd2, 14'd0);
        repeat (5) send_item(KIND_TICK, 1'b0);
        repeat (3) send_item(KIND_TICK, 1'b0);
        send_item(KIND_PIN, 1'b0);
        send_item(KIND_PIN, 1'b0);
        repeat (3) send_item(KIND_TICK, 1'b0);
        send_item(KIND_ACTIVITY, 1'b0);
        repeat (3) send_item(KIND_TICK, 1'b0);
        send_item(KIND_STAY, 1'b1);
        repeat (2) send_item(KIND_TICK, 1'b0);
        send_item(KIND_STAY, 1'b0);
        repeat (2) send_item(KIND_TICK, 1'b1);
        send_item(KIND_ACTIVITY, 1'b1);
        wait_all_reports();

        for (int p = 0; p < RandPhases; p++)
        begin
            case (p)
                0:       set_timing(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 14'h3FFF);
                1:       set_timing(24'd0, 16'd0, 24'd0, 14'd0);
                2:       set_timing(24'd0, 16'd0, 24'd1, 14'd1);
                default: set_timing(24'($urandom_range(0, 8)), 16'($urandom_range(0, 6)),
                                    24'($urandom_range(0, 15)), 14'($urandom_range(0, 12)));
            endcase
            send_random_phase(PhaseItems);
            wait_all_reports();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
